>>> design/xsk_pkg.sv
// Shared types, constants and helper functions for the Xoodoo sponge keystream block.
package xsk_pkg;

  localparam int unsigned NumLanes  = 12;
  localparam int unsigned LaneW     = 32;
  localparam int unsigned NumRounds = 12;
  localparam int unsigned RoundW    = $clog2(NumRounds);
  localparam logic [RoundW-1:0] LastRound = RoundW'(NumRounds - 1);

  localparam logic [7:0] PadFirst = 8'h1F;
  localparam logic [7:0] PadLast  = 8'h80;

  // Action carried with every item
  typedef enum logic [1:0] {
    ACT_ABSORB  = 2'd0,
    ACT_FINAL   = 2'd1,
    ACT_SQUEEZE = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef logic [NumLanes-1:0][LaneW-1:0] lanes_t;
  typedef logic [3:0][LaneW-1:0]          rate_t;

  // Command handed from the stream port to the core on acceptance
  typedef struct packed {
    logic       start;
    action_e    action;
    rate_t      words;
    logic [3:0] byte_count;
  } cmd_t;

  function automatic logic [LaneW-1:0] rotl(input logic [LaneW-1:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (LaneW - n));
  endfunction

  // Round constants, iota step
  function automatic logic [LaneW-1:0] round_const(input logic [RoundW-1:0] r);
    logic [LaneW-1:0] c;
    unique case (r)
      4'd0:    c = 32'h058;
      4'd1:    c = 32'h038;
      4'd2:    c = 32'h3C0;
      4'd3:    c = 32'h0D0;
      4'd4:    c = 32'h120;
      4'd5:    c = 32'h014;
      4'd6:    c = 32'h060;
      4'd7:    c = 32'h02C;
      4'd8:    c = 32'h380;
      4'd9:    c = 32'h0F0;
      4'd10:   c = 32'h1A0;
      4'd11:   c = 32'h012;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> design/xsk_round.sv
// One Xoodoo round: theta, rho-west, iota, chi and rho-east.
module xsk_round (
  input  xsk_pkg::lanes_t           lanes_i,
  input  logic [xsk_pkg::LaneW-1:0] rc_i,
  output xsk_pkg::lanes_t           lanes_o
);

  logic [3:0][xsk_pkg::LaneW-1:0] p, e, a0, a1, a2, w1, w2, b0, b1, b2;

  always_comb begin
    // theta: column parity folded back in
    for (int x = 0; x < 4; x++) begin
      p[x] = lanes_i[x] ^ lanes_i[x+4] ^ lanes_i[x+8];
    end
    for (int x = 0; x < 4; x++) begin
      e[x] = xsk_pkg::rotl(p[(x+3)%4], 5) ^ xsk_pkg::rotl(p[(x+3)%4], 14);
    end
    for (int x = 0; x < 4; x++) begin
      a0[x] = lanes_i[x]   ^ e[x];
      a1[x] = lanes_i[x+4] ^ e[x];
      a2[x] = lanes_i[x+8] ^ e[x];
    end
    // rho-west
    for (int x = 0; x < 4; x++) begin
      w1[x] = a1[(x+3)%4];
      w2[x] = xsk_pkg::rotl(a2[x], 11);
    end
    // iota on lane zero, then chi
    for (int x = 0; x < 4; x++) begin
      b0[x] = (x == 0) ? (a0[x] ^ rc_i) : a0[x];
    end
    for (int x = 0; x < 4; x++) begin
      a0[x] = b0[x] ^ (~w1[x] & w2[x]);
      b1[x] = w1[x] ^ (~w2[x] & b0[x]);
      b2[x] = w2[x] ^ (~b0[x] & w1[x]);
    end
    // rho-east
    for (int x = 0; x < 4; x++) begin
      lanes_o[x]   = a0[x];
      lanes_o[x+4] = xsk_pkg::rotl(b1[x], 1);
      lanes_o[x+8] = xsk_pkg::rotl(b2[(x+2)%4], 8);
    end
  end

endmodule

>>> design/xsk_core.sv
// Sponge state register, block injection and round sequencer around the shared round unit.
module xsk_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  xsk_pkg::cmd_t  cmd_i,
  output logic           busy_o,
  output xsk_pkg::rate_t rate_o
);

  xsk_pkg::lanes_t            state_q, state_d, round_out;
  logic [xsk_pkg::RoundW-1:0] rnd_q, rnd_d;
  logic                       busy_q, busy_d;
  logic [15:0][7:0]           inj;
  logic [15:0][7:0]           msg;

  xsk_round u_round (
    .lanes_i (state_q),
    .rc_i    (xsk_pkg::round_const(rnd_q)),
    .lanes_o (round_out)
  );

  // Bytes to XOR into the rate: plain block, or masked and padded final block; zero otherwise
  always_comb begin
    msg = cmd_i.words;
    for (int j = 0; j < 16; j++) begin
      unique case (cmd_i.action)
        xsk_pkg::ACT_ABSORB: inj[j] = msg[j];
        xsk_pkg::ACT_FINAL: begin
          inj[j] = (4'(j) < cmd_i.byte_count) ? msg[j] : 8'h00;
          if (4'(j) == cmd_i.byte_count) begin
            inj[j] = inj[j] ^ xsk_pkg::PadFirst;
          end
          if (j == 15) begin
            inj[j] = inj[j] ^ xsk_pkg::PadLast;
          end
        end
        default: inj[j] = 8'h00;
      endcase
    end
  end

  // Sequencer: inject on acceptance, then twelve rounds; a clear zeroes the state
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    busy_d  = busy_q;
    if (busy_q) begin
      state_d = round_out;
      rnd_d   = rnd_q + 1'b1;
      if (rnd_q == xsk_pkg::LastRound) begin
        busy_d = 1'b0;
      end
    end else if (cmd_i.start) begin
      if (cmd_i.action == xsk_pkg::ACT_CLEAR) begin
        state_d = '0;
      end else begin
        state_d[3:0] = state_q[3:0] ^ xsk_pkg::rate_t'(inj);
        rnd_d        = '0;
        busy_d       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      rnd_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign rate_o = state_q[3:0];

endmodule

>>> design/xoodoo_sponge_keystream.sv
// Top level: stream ports, two-entry output queue and the sponge core.
//
// Xoodoo sponge keystream engine. Items arrive on the s_axis channel; the
// action travels in s_axis_tuser and the four message words plus the final
// byte count in s_axis_tdata. Absorb, final absorb and squeeze items each
// inject the block into the state and then run twelve rounds, in which the
// single round unit is reused, one round per cycle, under a round counter.
// A clear item zeroes the state and runs no rounds. s_axis_tready is low
// while the rounds run.
// A squeeze item returns the 16 rate bytes, taken before the permutation,
// on m_axis; the result is registered into the output queue on acceptance.
// The other actions return nothing.
// Results go into a two-entry output queue, so the engine carries on
// while the receiver stalls; only when both entries are full does it hold
// s_axis_tready low until one is taken.
// Reset clears the whole state to zero and empties the output queue.
module xoodoo_sponge_keystream (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] in_word0, [63:32] in_word1, [95:64] in_word2, [127:96] in_word3,
  // [131:128] byte_count, [135:132] zero
  input  logic [135:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] out_word0, [63:32] out_word1, [95:64] out_word2, [127:96] out_word3
  output logic [127:0] m_axis_tdata
);

  xsk_pkg::cmd_t  cmd;
  xsk_pkg::rate_t rate;
  logic           busy;
  logic           accept, push, pop;
  logic           out_v_q, hold_v_q;
  logic [127:0]   out_q, hold_q;

  assign s_axis_tready = !busy && !(out_v_q && hold_v_q);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Command to the core
  always_comb begin
    cmd.start      = accept;
    cmd.action     = xsk_pkg::action_e'(s_axis_tuser);
    cmd.words      = xsk_pkg::rate_t'(s_axis_tdata[127:0]);
    cmd.byte_count = s_axis_tdata[131:128];
  end

  xsk_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .busy_o (busy),
    .rate_o (rate)
  );

  assign push = accept && (cmd.action == xsk_pkg::ACT_SQUEEZE);
  assign pop  = m_axis_tvalid && m_axis_tready;

  // Output queue valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
    end else if (pop) begin
      if (hold_v_q) begin
        hold_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      if (out_v_q) begin
        hold_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end
  end

  // Output queue payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (hold_v_q) begin
        out_q <= hold_q;
      end else if (push) begin
        out_q <= 128'(rate);
      end
    end else if (push) begin
      if (out_v_q) begin
        hold_q <= 128'(rate);
      end else begin
        out_q <= 128'(rate);
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // A permuting item keeps the port closed for the rounds that follow
  a_busy_after_absorb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd.action != xsk_pkg::ACT_CLEAR) |=> !s_axis_tready)
    else $error("input taken while rounds pending");

  // A squeeze always leaves a result waiting
  a_squeeze_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> m_axis_tvalid)
    else $error("squeeze result lost");

  // The second queue entry is only used behind the first
  a_queue_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q |-> out_v_q)
    else $error("hold entry valid with empty head");

endmodule
